### src/bounded_priority_queue_top_macros.svh
// assertion macros used by the checker file
`ifndef BOUNDED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define BOUNDED_PRIORITY_QUEUE_TOP_MACROS_SVH

// clocked assertion that is off while reset is asserted
`define BPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also watches the reset cycles
`define BPQ_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/bpq_pkg.sv
// shared types, widths and codes of the bounded priority queue
package bpq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int PRI_W     = 16;
    localparam int DATA_W    = 32;
    localparam int STAT_W    = 3;
    localparam int FILL_W    = 5;
    localparam int CAP_W     = 5;
    localparam int CMD_W     = 1;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int IN_TDW    = 48;
    localparam int OUT_TDW   = 56;

    localparam logic [CAP_W-1:0]  CAP_RESET    = 5'd16;
    localparam logic [APB_AW-1:0] ADDR_CAPACITY = 3'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } t_cmd_code;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_EVICTED  = 3'd1,
        ST_REJECTED = 3'd2,
        ST_DEQUEUED = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // run the operation and load the result register
    } t_ctrl_cmd;

endpackage

### src/bpq_datapath.sv
// sorted entry cells, per-cell compare and result register
module bpq_datapath #(
    parameter int DEPTH = bpq_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpq_pkg::t_ctrl_cmd            i_cmd,
    input  logic [bpq_pkg::CAP_W-1:0]     i_capacity,
    input  logic [bpq_pkg::CMD_W-1:0]     i_command,
    input  logic [bpq_pkg::PRI_W-1:0]     i_new_priority,
    input  logic signed [bpq_pkg::DATA_W-1:0] i_new_data,
    output logic [bpq_pkg::STAT_W-1:0]    o_status,
    output logic [bpq_pkg::PRI_W-1:0]     o_out_priority,
    output logic signed [bpq_pkg::DATA_W-1:0] o_out_data,
    output logic [bpq_pkg::FILL_W-1:0]    o_fill_level
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > bpq_pkg::CAP_W) ? CW : bpq_pkg::CAP_W;

    // captured item
    logic [bpq_pkg::CMD_W-1:0]      r_cmd;
    logic [bpq_pkg::PRI_W-1:0]      r_pri;
    logic [bpq_pkg::DATA_W-1:0]     r_dat;

    // cells, highest priority in cell 0
    logic [bpq_pkg::PRI_W-1:0]      r_slot_pri [DEPTH];
    logic [bpq_pkg::DATA_W-1:0]     r_slot_dat [DEPTH];
    logic [bpq_pkg::PRI_W-1:0]      n_slot_pri [DEPTH];
    logic [bpq_pkg::DATA_W-1:0]     n_slot_dat [DEPTH];
    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  n_count;

    // result register
    logic [bpq_pkg::STAT_W-1:0]     r_status, n_status;
    logic [bpq_pkg::PRI_W-1:0]      r_opri, n_opri;
    logic [bpq_pkg::DATA_W-1:0]     r_odat, n_odat;
    logic [bpq_pkg::FILL_W-1:0]     r_fill;

    // per-cell views
    logic [DEPTH-1:0]               ge;        // held and priority >= new
    logic [DEPTH-1:0]               held;
    logic [DEPTH-1:0]               prev_ge;
    logic [bpq_pkg::PRI_W-1:0]      prev_pri [DEPTH];
    logic [bpq_pkg::DATA_W-1:0]     prev_dat [DEPTH];
    logic [bpq_pkg::PRI_W-1:0]      next_pri [DEPTH];
    logic [bpq_pkg::DATA_W-1:0]     next_dat [DEPTH];

    logic [KW-1:0]                  cap_ext;
    logic [KW-1:0]                  eff_cap;
    logic                           room;
    logic                           outranks;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign held[g] = CW'(g) < r_count;
        assign ge[g]   = held[g] && (r_slot_pri[g] >= r_pri);
        if (g == 0) begin : g_head
            assign prev_ge[g]  = 1'b1;
            assign prev_pri[g] = r_pri;
            assign prev_dat[g] = r_dat;
        end else begin : g_body
            assign prev_ge[g]  = ge[g-1];
            assign prev_pri[g] = r_slot_pri[g-1];
            assign prev_dat[g] = r_slot_dat[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign next_pri[g] = r_slot_pri[g];
            assign next_dat[g] = r_slot_dat[g];
        end else begin : g_inner
            assign next_pri[g] = r_slot_pri[g+1];
            assign next_dat[g] = r_slot_dat[g+1];
        end
    end

    always_comb begin
        cap_ext = KW'(i_capacity);
        if (cap_ext == '0) begin
            eff_cap = KW'(1);
        end else if (cap_ext > KW'(DEPTH)) begin
            eff_cap = KW'(DEPTH);
        end else begin
            eff_cap = cap_ext;
        end
        room     = KW'(r_count) < eff_cap;
        // some held entry ranks strictly below the new one
        outranks = |(held & ~ge);
    end

    always_comb begin
        n_slot_pri = r_slot_pri;
        n_slot_dat = r_slot_dat;
        n_count    = r_count;
        n_status   = bpq_pkg::ST_REJECTED;
        n_opri     = '0;
        n_odat     = '0;
        case (r_cmd)
            bpq_pkg::CMD_DEQUEUE: begin
                if (r_count == '0) begin
                    n_status = bpq_pkg::ST_EMPTY;
                end else begin
                    n_status   = bpq_pkg::ST_DEQUEUED;
                    n_opri     = r_slot_pri[0];
                    n_odat     = r_slot_dat[0];
                    n_slot_pri = next_pri;
                    n_slot_dat = next_dat;
                    n_count    = r_count - CW'(1);
                end
            end
            bpq_pkg::CMD_ENQUEUE: begin
                if (room || outranks) begin
                    n_status = room ? bpq_pkg::ST_INSERTED : bpq_pkg::ST_EVICTED;
                    // eviction keeps the count, the lowest entry drops past the end
                    if (room) begin
                        n_count = r_count + CW'(1);
                    end
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!ge[i]) begin
                            if (prev_ge[i]) begin
                                n_slot_pri[i] = r_pri;
                                n_slot_dat[i] = r_dat;
                            end else begin
                                n_slot_pri[i] = prev_pri[i];
                                n_slot_dat[i] = prev_dat[i];
                            end
                        end
                    end
                end
            end
            default: begin
                n_status = bpq_pkg::ST_REJECTED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_pri <= i_new_priority;
            r_dat <= i_new_data;
        end
        if (i_cmd.exec) begin
            r_slot_pri <= n_slot_pri;
            r_slot_dat <= n_slot_dat;
            r_status   <= n_status;
            r_opri     <= n_opri;
            r_odat     <= n_odat;
            r_fill     <= bpq_pkg::FILL_W'(n_count);
        end
    end

    assign o_status       = r_status;
    assign o_out_priority = r_opri;
    assign o_out_data     = r_odat;
    assign o_fill_level   = r_fill;

endmodule

### src/bpq_ctrl.sv
// handshake controller: accepts an item, runs it, holds the result valid
module bpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output bpq_pkg::t_ctrl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        // the result register is free when it holds no result or its item is taken this cycle
        out_free    = !r_out_valid || i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### src/bounded_priority_queue_top.sv
// an accepted item is captured, then run and its result registered once the result register is free
// a new item is taken only while idle, after the last one has been run
// every operation runs over all cells at once, compared in parallel
// reset clears the entry count, the handshake state and sets capacity to 16
// entry contents are not cleared; no clearing pass, items accepted right after reset
module bounded_priority_queue_top #(
    parameter int DEPTH = bpq_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bpq_pkg::IN_TDW-1:0]    s_axis_tdata,   // new_priority, new_data
    input  logic [bpq_pkg::CMD_W-1:0]     s_axis_tuser,   // command
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [bpq_pkg::OUT_TDW-1:0]   m_axis_tdata,   // out_priority, out_data, fill_level
    output logic [bpq_pkg::STAT_W-1:0]    m_axis_tuser,   // status
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpq_pkg::APB_AW-1:0]    paddr,
    input  logic [bpq_pkg::APB_DW-1:0]    pwdata,
    output logic [bpq_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    bpq_pkg::t_ctrl_cmd              cmd;
    logic [bpq_pkg::CAP_W-1:0]       r_capacity;
    logic [bpq_pkg::PRI_W-1:0]       out_priority;
    logic signed [bpq_pkg::DATA_W-1:0] out_data;
    logic [bpq_pkg::FILL_W-1:0]      fill_level;
    logic [bpq_pkg::STAT_W-1:0]      status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= bpq_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr == bpq_pkg::ADDR_CAPACITY) begin
            r_capacity <= pwdata[bpq_pkg::CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == bpq_pkg::ADDR_CAPACITY) begin
            prdata = bpq_pkg::APB_DW'(r_capacity);
        end
    end

    bpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    bpq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_capacity     (r_capacity),
        .i_command      (s_axis_tuser),
        .i_new_priority (s_axis_tdata[bpq_pkg::PRI_W-1:0]),
        .i_new_data     (s_axis_tdata[bpq_pkg::PRI_W +: bpq_pkg::DATA_W]),
        .o_status       (status),
        .o_out_priority (out_priority),
        .o_out_data     (out_data),
        .o_fill_level   (fill_level)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = {3'b000, fill_level, out_data, out_priority};

endmodule

### src/bpq_checker.sv
// port-level checks of the bounded priority queue and their binding
`include "bounded_priority_queue_top_macros.svh"

module bpq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [bpq_pkg::OUT_TDW-1:0]   m_axis_tdata,
    input logic [bpq_pkg::STAT_W-1:0]    m_axis_tuser
);

    // a result exists only after an item has gone through
    `BPQ_ASSERT_RST(a_no_valid_after_reset, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid right after reset")

    // only a dequeue carries an entry
    `BPQ_ASSERT(a_zero_unless_dequeued, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != bpq_pkg::ST_DEQUEUED |-> m_axis_tdata[47:0] == 48'd0, "entry fields set without a dequeue")

    // empty reports leave nothing held
    `BPQ_ASSERT(a_empty_fill_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == bpq_pkg::ST_EMPTY |-> m_axis_tdata[52:48] == 5'd0, "empty status with entries held")

    // a stalled result holds
    `BPQ_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind bounded_priority_queue_top bpq_checker u_bpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### bench/bounded_priority_queue_top_tb.sv
// self-checking testbench of the bounded priority queue: directed table, then random phases
module bounded_priority_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          QDEPTH      = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          RAND_PHASES = 10;
    localparam int          PHASE_ITEMS = 150;

    typedef struct packed {
        bpq_pkg::t_status status;
        logic [15:0]     pri;
        logic [31:0]     data;
        logic [4:0]      fill;
    } t_qresult;

    typedef enum bit {ROW_ITEM, ROW_CAP} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        bpq_pkg::t_cmd_code cmd;
        logic [15:0]        pri;
        logic [31:0]        data;   // capacity value on a ROW_CAP row
        bit                 typed;
        t_qresult           want;
    } t_stim_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [bpq_pkg::IN_TDW-1:0]    s_axis_tdata = '0;   // new_priority, new_data
    logic [bpq_pkg::CMD_W-1:0]     s_axis_tuser = '0;   // command
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [bpq_pkg::OUT_TDW-1:0]   m_axis_tdata;        // out_priority, out_data, fill_level
    logic [bpq_pkg::STAT_W-1:0]    m_axis_tuser;        // status
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [bpq_pkg::APB_AW-1:0]    paddr = '0;
    logic [bpq_pkg::APB_DW-1:0]    pwdata = '0;
    logic [bpq_pkg::APB_DW-1:0]    prdata;
    logic                          pready;

    bounded_priority_queue_top #(.DEPTH(QDEPTH)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the sorted queue, highest priority first
    logic [15:0] shadow_pri [QDEPTH];
    logic [31:0] shadow_pay [QDEPTH];
    int          shadow_count = 0;
    logic [4:0]  shadow_cap = bpq_pkg::CAP_RESET;

    t_qresult    pending_results [$];
    t_stim_row   dir_rows [$];

    int          fails = 0;
    int          items_sent = 0;
    int          caps_written = 0;
    int          status_tally [8];
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    int          rx_mode = 0;
    int          rx_mode_left = 0;
    int          rx_stall_left = 0;
    bit          rx_ready_next;

    // insert after every entry of equal or higher priority; caller makes room
    function automatic void place_entry(logic [15:0] pri, logic [31:0] pay);
        int pos;
        pos = 0;
        while (pos < shadow_count && shadow_pri[pos] >= pri) pos++;
        for (int k = shadow_count; k > pos; k--) begin
            shadow_pri[k] = shadow_pri[k-1];
            shadow_pay[k] = shadow_pay[k-1];
        end
        shadow_pri[pos] = pri;
        shadow_pay[pos] = pay;
        shadow_count++;
    endfunction

    function automatic t_qresult apply_queue_op(bpq_pkg::t_cmd_code cmd, logic [15:0] pri,
                                                logic [31:0] pay);
        t_qresult r;
        int       eff;
        r   = '0;
        eff = (shadow_cap == 0) ? 1 : (int'(shadow_cap) > QDEPTH ? QDEPTH : int'(shadow_cap));
        if (cmd == bpq_pkg::CMD_DEQUEUE) begin
            if (shadow_count == 0) begin
                r.status = bpq_pkg::ST_EMPTY;
            end else begin
                r.status = bpq_pkg::ST_DEQUEUED;
                r.pri    = shadow_pri[0];
                r.data   = shadow_pay[0];
                for (int k = 1; k < shadow_count; k++) begin
                    shadow_pri[k-1] = shadow_pri[k];
                    shadow_pay[k-1] = shadow_pay[k];
                end
                shadow_count--;
            end
        end else if (shadow_count < eff) begin
            place_entry(pri, pay);
            r.status = bpq_pkg::ST_INSERTED;
        end else if (pri > shadow_pri[shadow_count-1]) begin
            // full (or over a lowered capacity): the lowest entry gives way
            shadow_count--;
            place_entry(pri, pay);
            r.status = bpq_pkg::ST_EVICTED;
        end else begin
            r.status = bpq_pkg::ST_REJECTED;
        end
        r.fill = shadow_count[4:0];
        return r;
    endfunction

    function automatic void row_item(bpq_pkg::t_cmd_code cmd, logic [15:0] pri,
                                     logic [31:0] data);
        t_stim_row row;
        row = '{kind: ROW_ITEM, cmd: cmd, pri: pri, data: data, typed: 1'b0, want: '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void row_known(bpq_pkg::t_cmd_code cmd, logic [15:0] pri,
                                      logic [31:0] data, bpq_pkg::t_status st,
                                      logic [15:0] opri, logic [31:0] odata,
                                      logic [4:0] fill);
        t_stim_row row;
        t_qresult  w;
        w = '0;
        w.status = st;
        w.pri    = opri;
        w.data   = odata;
        w.fill   = fill;
        row = '{kind: ROW_ITEM, cmd: cmd, pri: pri, data: data, typed: 1'b1, want: w};
        dir_rows.push_back(row);
    endfunction

    function automatic void row_cap(logic [31:0] value);
        t_stim_row row;
        row = '{kind: ROW_CAP, cmd: bpq_pkg::CMD_ENQUEUE, pri: '0, data: value, typed: 1'b0,
                want: '0};
        dir_rows.push_back(row);
    endfunction

    task automatic send_item(bpq_pkg::t_cmd_code cmd, logic [15:0] pri, logic [31:0] pay,
                             bit typed, t_qresult want);
        t_qresult predicted;
        int       gap;
        s_axis_tdata  <= {pay, pri};
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predicted = apply_queue_op(cmd, pri, pay);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 12);
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;
                5:       gap = $urandom_range(10, 30);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // stop sending and wait until every item has its result back
    task automatic drain_queue_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // write the capacity register, then read it back
    task automatic write_capacity(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bpq_pkg::ADDR_CAPACITY;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== bpq_pkg::APB_DW'(value[4:0])) begin
            $error("capacity mismatch: expected %0d, actual %0d", value[4:0], prdata);
            fails++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        shadow_cap = value[4:0];
        caps_written++;
    endtask

    task automatic check_result();
        t_qresult want;
        if (pending_results.size() == 0) begin
            $error("result with no item waiting: status %0d", m_axis_tuser);
            fails++;
            return;
        end
        want = pending_results.pop_front();
        status_tally[m_axis_tuser]++;
        if (m_axis_tuser !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, m_axis_tuser);
            fails++;
        end
        if (m_axis_tdata[15:0] !== want.pri) begin
            $error("out_priority mismatch: expected %0h, actual %0h",
                   want.pri, m_axis_tdata[15:0]);
            fails++;
        end
        if (m_axis_tdata[47:16] !== want.data) begin
            $error("out_data mismatch: expected %0h, actual %0h",
                   want.data, m_axis_tdata[47:16]);
            fails++;
        end
        if (m_axis_tdata[52:48] !== want.fill) begin
            $error("fill_level mismatch: expected %0d, actual %0d",
                   want.fill, m_axis_tdata[52:48]);
            fails++;
        end
    endtask

    // result side: check each accepted item, then pick the next ready value
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) check_result();
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(64, 256);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: rx_ready_next = 1'b1;
                1: rx_ready_next = $urandom_range(0, 1);
                default: begin
                    if (rx_stall_left > 0) begin
                        rx_stall_left--;
                        rx_ready_next = 1'b0;
                    end else if ($urandom_range(0, 15) == 0) begin
                        rx_stall_left = $urandom_range(5, 25);
                        rx_ready_next = 1'b0;
                    end else begin
                        rx_ready_next = 1'b1;
                    end
                end
            endcase
            m_axis_tready <= rx_ready_next;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bounded_priority_queue_top verification failed");
            $finish;
        end
    end

    initial begin : main_seq
        bpq_pkg::t_cmd_code cmd;
        logic [15:0]        pri;
        logic [31:0]        cap_value;
        int                 enq_pct;
        int                 cap_plan [RAND_PHASES];

        cap_plan = '{31, 0, 1, 2, 16, 17, 4, 8, 0, 3};
        foreach (status_tally[i]) status_tally[i] = 0;

        // extremes and fifo order among equal priorities at reset capacity
        row_known(bpq_pkg::CMD_DEQUEUE, 16'h1234, 32'h5678_9abc, bpq_pkg::ST_EMPTY,
                  16'h0, 32'h0, 5'd0);
        row_known(bpq_pkg::CMD_ENQUEUE, 16'hffff, 32'h7fff_ffff, bpq_pkg::ST_INSERTED,
                  16'h0, 32'h0, 5'd1);
        row_known(bpq_pkg::CMD_ENQUEUE, 16'h0000, 32'h8000_0000, bpq_pkg::ST_INSERTED,
                  16'h0, 32'h0, 5'd2);
        row_item(bpq_pkg::CMD_ENQUEUE, 16'h8000, 32'h0000_0001);
        row_item(bpq_pkg::CMD_ENQUEUE, 16'h8000, 32'h0000_0002);
        row_known(bpq_pkg::CMD_DEQUEUE, 16'h0000, 32'h0000_0000, bpq_pkg::ST_DEQUEUED,
                  16'hffff, 32'h7fff_ffff, 5'd3);
        row_item(bpq_pkg::CMD_DEQUEUE, 16'hffff, 32'hffff_ffff);
        row_item(bpq_pkg::CMD_DEQUEUE, 16'h0000, 32'h0000_0000);
        row_item(bpq_pkg::CMD_DEQUEUE, 16'h5555, 32'haaaa_aaaa);
        row_known(bpq_pkg::CMD_DEQUEUE, 16'haaaa, 32'h5555_5555, bpq_pkg::ST_EMPTY,
                  16'h0, 32'h0, 5'd0);
        // zero capacity behaves as one: equal priority rejected, higher evicts
        row_cap(32'd0);
        row_item(bpq_pkg::CMD_ENQUEUE, 16'd5, 32'd10);
        row_known(bpq_pkg::CMD_ENQUEUE, 16'd5, 32'd11, bpq_pkg::ST_REJECTED,
                  16'h0, 32'h0, 5'd1);
        row_item(bpq_pkg::CMD_ENQUEUE, 16'd4, 32'd12);
        row_item(bpq_pkg::CMD_ENQUEUE, 16'd6, 32'd13);
        row_cap(32'd3);
        row_item(bpq_pkg::CMD_ENQUEUE, 16'd1, 32'd14);
        row_item(bpq_pkg::CMD_ENQUEUE, 16'd2, 32'd15);
        // capacity lowered below the fill: entries stay, eviction keeps the count
        row_cap(32'd1);
        row_item(bpq_pkg::CMD_ENQUEUE, 16'd0, 32'd16);
        row_item(bpq_pkg::CMD_ENQUEUE, 16'd7, 32'd17);
        row_item(bpq_pkg::CMD_ENQUEUE, 16'd2, 32'd18);
        row_item(bpq_pkg::CMD_DEQUEUE, 16'd0, 32'd0);
        row_item(bpq_pkg::CMD_DEQUEUE, 16'd0, 32'd0);
        row_item(bpq_pkg::CMD_DEQUEUE, 16'd0, 32'd0);
        row_item(bpq_pkg::CMD_DEQUEUE, 16'd0, 32'd0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < dir_rows.size(); i++) begin
            if (dir_rows[i].kind == ROW_CAP) begin
                drain_queue_results();
                write_capacity(dir_rows[i].data);
            end else begin
                send_item(dir_rows[i].cmd, dir_rows[i].pri, dir_rows[i].data,
                          dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // random phases; the queue keeps its contents across capacity changes
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_queue_results();
            cap_value = cap_plan[ph];
            if (ph == 8) cap_value = $urandom;   // random value, upper bits ignored
            write_capacity(cap_value);
            case ($urandom_range(0, 2))
                0:       enq_pct = 35;
                1:       enq_pct = 55;
                default: enq_pct = 75;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                cmd = ($urandom_range(0, 99) < enq_pct) ? bpq_pkg::CMD_ENQUEUE
                                                        : bpq_pkg::CMD_DEQUEUE;
                case ($urandom_range(0, 3))
                    0:       pri = 16'($urandom_range(0, 65535));
                    1:       pri = 16'($urandom_range(0, 7));
                    2:       pri = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
                    default: pri = 16'($urandom_range(65528, 65535));
                endcase
                send_item(cmd, pri, $urandom, 1'b0, '0);
            end
        end

        drain_queue_results();
        repeat (8) @(posedge i_clk);

        $display("sent %0d items across %0d capacity writes, capacities between 0 and 31",
                 items_sent, caps_written);
        $display("results: %0d inserted, %0d evicted, %0d rejected, %0d dequeued, %0d empty",
                 status_tally[bpq_pkg::ST_INSERTED], status_tally[bpq_pkg::ST_EVICTED],
                 status_tally[bpq_pkg::ST_REJECTED], status_tally[bpq_pkg::ST_DEQUEUED],
                 status_tally[bpq_pkg::ST_EMPTY]);
        if (fails == 0) begin
            $display("bounded_priority_queue_top verification clean");
        end else begin
            $display("bounded_priority_queue_top verification failed");
        end
        $finish;
    end

endmodule
